/* rtl/core/sha256_pkg.sv */
// Shared constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef logic [31:0] word_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(input word_t x, input word_t y, input word_t z);
		choose = (x & y) ^ (~x & z);
	endfunction

	function automatic word_t majority(input word_t x, input word_t y, input word_t z);
		majority = (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage

/* rtl/core/sha256_stream_hasher_core.sv */
// SHA-256 stream hasher: byte intake, padding sequencer and a single-round compression unit.
// Each accepted byte lands in a 512-bit block window. A full block is compressed
// by one round unit that runs one round per cycle, 64 rounds and then one
// chaining add. On the end-of-message item the sequencer writes the padding
// bytes itself, one per cycle, up to the end of the block (a second block when
// fewer than nine bytes are left), compresses, and then offers the digest as
// four 64-bit big-endian transfers, first part first. The input stalls from the
// end of a block or message until its work is done.
module sha256_stream_hasher_core
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  byte_data,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [63:0] digest_part,
	output logic [1:0]  part_index,
	output logic        last_part
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam int unsigned FillW  = $clog2(BlockBytes);
	localparam int unsigned RoundW = $clog2(Rounds);
	localparam int unsigned WinW   = BlockBytes * 8;

	localparam logic [FillW-1:0]  FILL_LAST  = FillW'(BlockBytes - 1);
	localparam logic [FillW-1:0]  FILL_LEN   = FillW'(BlockBytes - 8);
	localparam logic [RoundW-1:0] ROUND_LAST = RoundW'(Rounds - 1);

	logic [2:0]        state_q;
	logic [FillW-1:0]  fill_q;
	logic [63:0]       bits_q;
	logic              pad_q;
	logic              mark_q;
	logic              len_ok_q;
	logic [RoundW-1:0] rnd_q;
	logic [1:0]        part_q;
	word_t             chain_q [8];
	word_t             work_q [8];
	logic [WinW-1:0]   win_q;

	logic        accept;
	logic        shift_byte;
	logic        start_comp;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic [7:0]  byte_in;
	word_t       w_new;
	word_t       t1;
	word_t       t2;

	assign accept = (state_q == ST_IDLE) && item_valid;

	// Message schedule taps: word j of the window is win_q[WinW-1-32*j -: 32].
	assign w_new = small_sigma1(win_q[WinW-1-32*14 -: 32]) + win_q[WinW-1-32*9 -: 32]
		+ small_sigma0(win_q[WinW-1-32*1 -: 32]) + win_q[WinW-1 -: 32];

	assign t1 = work_q[7] + big_sigma1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
		+ ROUND_K[rnd_q] + win_q[WinW-1 -: 32];
	assign t2 = big_sigma0(work_q[0]) + majority(work_q[0], work_q[1], work_q[2]);

	// Length bytes go out most significant first at block positions 56 to 63.
	assign len_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_ok_q && (fill_q >= FILL_LEN)) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign byte_in    = (state_q == ST_PAD) ? pad_byte : byte_data;
	assign shift_byte = (accept && byte_present) || (state_q == ST_PAD);
	assign start_comp = shift_byte && (fill_q == FILL_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			pad_q    <= 1'b0;
			mark_q   <= 1'b0;
			len_ok_q <= 1'b0;
			rnd_q    <= '0;
			part_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_HASH[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (byte_present) begin
							fill_q <= fill_q + 1'b1;
							bits_q <= bits_q + 64'd8;
						end
						if (start_comp) begin
							state_q <= ST_COMP;
							rnd_q   <= '0;
							pad_q   <= message_end;
						end else if (message_end) begin
							state_q <= ST_PAD;
							pad_q   <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 1'b1;
					if (!mark_q) begin
						mark_q <= 1'b1;
						// The length fits behind the marker only if it lands before byte 56.
						if (fill_q < FILL_LEN) begin
							len_ok_q <= 1'b1;
						end
					end
					if (start_comp) begin
						state_q <= ST_COMP;
						rnd_q   <= '0;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == ROUND_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
					if (!pad_q) begin
						state_q <= ST_IDLE;
					end else if (len_ok_q) begin
						state_q <= ST_OUT;
						part_q  <= '0;
					end else begin
						// A marker in the previous block means the next one carries the length.
						if (mark_q) begin
							len_ok_q <= 1'b1;
						end
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						part_q <= part_q + 1'b1;
						if (part_q == 2'd3) begin
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= INIT_HASH[i];
							end
							state_q  <= ST_IDLE;
							fill_q   <= '0;
							bits_q   <= '0;
							pad_q    <= 1'b0;
							mark_q   <= 1'b0;
							len_ok_q <= 1'b0;
						end else begin
							// Rotate so the next part always sits in the first two words.
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= chain_q[(i + 2) % 8];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (shift_byte) begin
			win_q <= {win_q[WinW-9:0], byte_in};
		end else if (state_q == ST_COMP) begin
			win_q <= {win_q[WinW-33:0], w_new};
		end
		if (start_comp) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_COMP) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign digest_part  = {chain_q[0], chain_q[1]};
	assign part_index   = part_q;
	assign last_part    = (part_q == 2'd3);

endmodule

/* rtl/core/sha256_checker.sv */
// Port-level checks for the SHA-256 stream hasher and the bind that attaches them.
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        digest_valid,
	input logic        digest_stall,
	input logic [63:0] digest_part,
	input logic [1:0]  part_index,
	input logic        last_part
);

	// The final flag marks exactly the fourth part.
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (last_part == (part_index == 2'd3)))
		else $error("last_part does not match part_index");

	// A held digest part stays put until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_stall) |=> (digest_valid && $stable(digest_part)))
		else $error("digest part changed while stalled");

	// Parts of one digest follow back to back in order.
	assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && !last_part) |=>
			(digest_valid && (part_index == 2'($past(part_index) + 2'd1))))
		else $error("digest parts out of sequence");

	// No new input is taken while a digest is being delivered.
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> item_stall)
		else $error("input accepted during digest delivery");

	// The digest ends after the transfer of its last part.
	assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && last_part) |=> !digest_valid)
		else $error("digest output continued past the last part");

endmodule

bind sha256_stream_hasher_core sha256_checker u_sha256_checker (.*);
